// ===== hw/rtl/ssrf_pkg.sv =====
// shared types, codes and bit-mask helpers for the spi slave with receive ring
// no dependencies
package ssrf_pkg;

    localparam int RING_DEPTH_DEF = 8;
    localparam int BYTE_W         = 8;
    localparam int S_TDATA_W      = 16;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 16;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    // function codes carried in s_tuser
    localparam logic [1:0] FUNC_CLK  = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;

    // edge modes
    localparam logic [1:0] EDGE_BOTH = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // register indexes (word address bit 2)
    localparam logic REG_EDGE_MODE = 1'b0;
    localparam logic REG_BIT_ORDER = 1'b1;

    localparam logic [1:0] EDGE_MODE_RST = EDGE_BOTH;
    localparam logic       BIT_ORDER_RST = 1'b1;

    localparam logic [BYTE_W-1:0] MASK_MSB = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LSB = 8'h01;

    typedef struct packed {
        logic [1:0] edge_mode;
        logic       bit_order;
    } cfg_t;

    // receive byte restart on a bit order write
    typedef struct packed {
        logic restart;
        logic order;
    } rx_restart_t;

    // classified item handed from front to back
    typedef struct packed {
        logic              is_clk;
        logic              is_pop;
        logic              is_load;
        logic              sample;
        logic              drive;
        logic              mosi;
        logic [BYTE_W-1:0] tx_byte;
    } op_t;

    function automatic logic [BYTE_W-1:0] first_mask(input logic order);
        first_mask = order ? MASK_MSB : MASK_LSB;
    endfunction

    function automatic logic [BYTE_W-1:0] last_mask(input logic order);
        last_mask = order ? MASK_LSB : MASK_MSB;
    endfunction

    function automatic logic [BYTE_W-1:0] next_mask(input logic order,
                                                    input logic [BYTE_W-1:0] m);
        next_mask = order ? (m >> 1) : (m << 1);
    endfunction

endpackage

// ===== hw/rtl/ssrf_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ssrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ssrf_front.sv =====
// front end: takes input beats and classifies them into ops for the back end
// depends on ssrf_pkg
module ssrf_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ssrf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ssrf_pkg::S_TUSER_W-1:0] s_tuser,
    input  ssrf_pkg::cfg_t                 cfg,
    input  logic                           q_full,
    output logic                           q_push,
    output ssrf_pkg::op_t                  q_op
);

    logic clk_level;
    logic mosi_level;
    logic [1:0] em;

    assign clk_level  = s_tdata[0];
    assign mosi_level = s_tdata[1];
    assign em         = cfg.edge_mode;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_op         = '0;
        q_op.mosi    = mosi_level;
        q_op.tx_byte = s_tdata[ssrf_pkg::BYTE_W+1:2];
        case (s_tuser)
            ssrf_pkg::FUNC_CLK: begin
                q_op.is_clk = 1'b1;
                q_op.sample = (em == ssrf_pkg::EDGE_BOTH)
                           || ((em == ssrf_pkg::EDGE_RISE) && clk_level)
                           || ((em == ssrf_pkg::EDGE_FALL) && !clk_level);
                q_op.drive  = (em == ssrf_pkg::EDGE_BOTH)
                           || ((em == ssrf_pkg::EDGE_RISE) && !clk_level)
                           || ((em == ssrf_pkg::EDGE_FALL) && clk_level);
            end
            ssrf_pkg::FUNC_POP: begin
                q_op.is_pop = 1'b1;
            end
            ssrf_pkg::FUNC_LOAD: begin
                q_op.is_load = 1'b1;
            end
            default: begin
                // unused code: status only
            end
        endcase
    end

endmodule

// ===== hw/rtl/ssrf_queue.sv =====
// two-entry op queue between front and back, full rate with push and pop together
// depends on ssrf_pkg
module ssrf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ssrf_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ssrf_pkg::op_t head_op
);

    ssrf_pkg::op_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hw/rtl/ssrf_back.sv =====
// back end: shift registers, receive ring and the registered result beat
// depends on ssrf_pkg and ssrf_ram
module ssrf_back #(
    parameter int RING_DEPTH = ssrf_pkg::RING_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ssrf_pkg::cfg_t                 cfg,
    input  ssrf_pkg::rx_restart_t          rx_restart,
    input  logic                           q_valid,
    input  ssrf_pkg::op_t                  q_op,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ssrf_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int BW = ssrf_pkg::BYTE_W;
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    logic [BW-1:0] rx_shift_reg, rx_shift_next;
    logic [BW-1:0] rx_mask_reg, rx_mask_next;
    logic [BW-1:0] tx_shift_reg, tx_shift_next;
    logic [BW-1:0] tx_mask_reg, tx_mask_next;
    logic          miso_reg, miso_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_miso_reg;
    logic          out_pop_reg;
    logic          out_avail_reg;
    logic          out_idle_reg;
    logic          out_drop_reg;

    logic          advance;
    logic          order;
    logic [BW-1:0] rx_filled;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic          ring_we;
    logic          ring_re;
    logic          pop_hit;
    logic          dropped;
    logic [BW-1:0] ring_rdata;

    assign order   = cfg.bit_order;
    assign advance = q_valid && (!out_valid_reg || m_tready);
    assign q_pop   = advance;

    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign rx_filled = rx_shift_reg | (q_op.mosi ? rx_mask_reg : '0);

    always_comb begin
        rx_shift_next = rx_shift_reg;
        rx_mask_next  = rx_mask_reg;
        tx_shift_next = tx_shift_reg;
        tx_mask_next  = tx_mask_reg;
        miso_next     = miso_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        pop_hit       = 1'b0;
        dropped       = 1'b0;
        if (advance) begin
            if (q_op.is_clk && q_op.sample) begin
                if (rx_mask_reg == ssrf_pkg::last_mask(order)) begin
                    ring_we       = 1'b1;
                    head_next     = head_inc;
                    // full ring: push over the oldest byte
                    if (head_inc == tail_reg) begin
                        tail_next = tail_inc;
                        dropped   = 1'b1;
                    end
                    rx_shift_next = '0;
                    rx_mask_next  = ssrf_pkg::first_mask(order);
                end else begin
                    rx_shift_next = rx_filled;
                    rx_mask_next  = ssrf_pkg::next_mask(order, rx_mask_reg);
                    if (rx_mask_next == '0) begin
                        rx_mask_next = ssrf_pkg::first_mask(order);
                    end
                end
            end
            if (q_op.is_clk && q_op.drive && (tx_mask_reg != '0)) begin
                miso_next = |(tx_shift_reg & tx_mask_reg);
                if (tx_mask_reg == ssrf_pkg::last_mask(order)) begin
                    tx_mask_next = '0;
                end else begin
                    tx_mask_next = ssrf_pkg::next_mask(order, tx_mask_reg);
                end
            end
            if (q_op.is_pop && (head_reg != tail_reg)) begin
                ring_re   = 1'b1;
                pop_hit   = 1'b1;
                tail_next = tail_inc;
            end
            if (q_op.is_load) begin
                tx_shift_next = q_op.tx_byte;
                tx_mask_next  = ssrf_pkg::first_mask(order);
            end
        end
        if (rx_restart.restart) begin
            rx_shift_next = '0;
            rx_mask_next  = ssrf_pkg::first_mask(rx_restart.order);
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_shift_reg  <= '0;
            rx_mask_reg   <= ssrf_pkg::first_mask(ssrf_pkg::BIT_ORDER_RST);
            tx_shift_reg  <= '0;
            tx_mask_reg   <= '0;
            miso_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rx_shift_reg  <= rx_shift_next;
            rx_mask_reg   <= rx_mask_next;
            tx_shift_reg  <= tx_shift_next;
            tx_mask_reg   <= tx_mask_next;
            miso_reg      <= miso_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_miso_reg  <= miso_next;
            out_pop_reg   <= pop_hit;
            out_avail_reg <= (head_next != tail_next);
            out_idle_reg  <= (tx_mask_next == '0);
            out_drop_reg  <= dropped;
        end
    end

    ssrf_ram #(
        .WIDTH (BW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata (rx_filled),
        .re    (ring_re),
        .raddr (tail_reg),
        .rdata (ring_rdata)
    );

    // read data is held by the ram until the next pop, so a stalled beat keeps it
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ssrf_pkg::M_TDATA_W - BW - 4){1'b0}},
                       out_drop_reg, out_idle_reg, out_avail_reg,
                       (out_pop_reg ? ring_rdata : {BW{1'b0}}),
                       out_miso_reg};

    a_rx_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(rx_mask_reg))
        else $error("receive bit mask lost its single bit");

    a_tx_mask_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tx_mask_reg))
        else $error("transmit bit mask has several bits");

    a_drop_leaves_data: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_drop_reg |-> out_avail_reg)
        else $error("drop reported with an empty ring");

    a_drop_only_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped |-> advance && q_op.is_clk && q_op.sample && ring_we)
        else $error("drop without a completed receive byte");

    a_pop_from_data: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_re |-> (head_reg != tail_reg) && !ring_we)
        else $error("ring read while empty or during a push");

endmodule

// ===== hw/rtl/spi_slave_with_rx_fifo_top.sv =====
// top level of the spi slave with receive ring: apb registers, front, queue, back
// depends on ssrf_pkg, ssrf_front, ssrf_queue, ssrf_back, ssrf_ram
//
//  channel   dir   handshake           payload
//  s_        in    s_tvalid/s_tready   s_tuser func, s_tdata clk/mosi/tx byte
//  m_        out   m_tvalid/m_tready   m_tdata miso/rx byte/status bits
//  apb       in    psel/penable        edge_mode at 0x0, bit_order at 0x4
//
// one beat per cycle sustained while the m_ side is not stalled; a beat's result passes through
// the queue and the output register (into the queue when taken, then by the back end into the output register)
// the back end updates all its state for a beat when it pops it from the queue; pops read the ring ram with a
// registered read that lines up with the output register
// a stalled m_ side fills the two-entry queue, then s_tready drops
// synchronous active-low reset clears pointers, shift masks and valids; ring needs no clear
module spi_slave_with_rx_fifo_top #(
    parameter int RING_DEPTH = ssrf_pkg::RING_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] clk_level, [1] mosi_level, [9:2] tx_byte, rest zero
    input  logic [ssrf_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [ssrf_pkg::S_TUSER_W-1:0]  s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] miso, [8:1] rx_byte, [9] rx_available, [10] tx_idle, [11] rx_dropped
    output logic [ssrf_pkg::M_TDATA_W-1:0]  m_tdata,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ssrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ssrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    ssrf_pkg::cfg_t        cfg_reg, cfg_next;
    ssrf_pkg::rx_restart_t rx_restart;
    ssrf_pkg::op_t         front_op;
    ssrf_pkg::op_t         queue_op;
    logic                  apb_wr;
    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;

    // register file
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (apb_wr) begin
            case (paddr[2])
                ssrf_pkg::REG_EDGE_MODE: cfg_next.edge_mode = pwdata[1:0];
                ssrf_pkg::REG_BIT_ORDER: cfg_next.bit_order = pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // a bit order write restarts the receive byte in the new order
    assign rx_restart.restart = apb_wr && (paddr[2] == ssrf_pkg::REG_BIT_ORDER);
    assign rx_restart.order   = pwdata[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_mode <= ssrf_pkg::EDGE_MODE_RST;
            cfg_reg.bit_order <= ssrf_pkg::BIT_ORDER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            ssrf_pkg::REG_EDGE_MODE: prdata[1:0] = cfg_reg.edge_mode;
            ssrf_pkg::REG_BIT_ORDER: prdata[0]   = cfg_reg.bit_order;
            default: begin
            end
        endcase
    end

    // classify incoming beats
    ssrf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    // decouples the input side from result stalls
    ssrf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (queue_op)
    );

    // shift registers, ring and result register
    ssrf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .rx_restart (rx_restart),
        .q_valid    (q_valid),
        .q_op       (queue_op),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
